// ===== rtl/rti_pkg.sv =====
`default_nettype none
package rti_pkg;

    // width of every configuration register
    localparam int CFG_W = 17;

    localparam logic [CFG_W-1:0] T_MIN_RST = 17'd33;
    localparam logic [CFG_W-1:0] TOL_RST   = 17'd7;
    localparam logic [CFG_W-1:0] EPS_RST   = 17'd0;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        VSEL_A = 2'd0,
        VSEL_B = 2'd1,
        VSEL_C = 2'd2
    } vsel_t;

    typedef enum logic [1:0] {
        CFG_T_MIN = 2'd0,
        CFG_TOL   = 2'd1,
        CFG_EPS   = 2'd2
    } cfg_idx_t;

    // control handed to each divider lane
    typedef struct packed {
        logic adv;
        logic flip;
    } div_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/rti_div.sv =====
`default_nettype none
module rti_div #(
    parameter int NW = 118,
    parameter int DW = 102,
    parameter int QW = 50
) (
    input  logic                  aclk,
    input  rti_pkg::div_ctl_t     ctl,
    input  logic [NW-1:0]         num,
    input  logic [DW-1:0]         den,
    output logic signed [QW:0]    quo
);

    // one quotient bit per stage, magnitude clamped to QW bits
    logic [NW-1:0] rem_reg [0:QW-1];
    logic [DW-1:0] den_reg [0:QW-1];
    logic [QW-1:0] q_reg   [0:QW];
    logic [QW:0]   ov_reg;
    logic [QW:0]   flip_reg;
    logic signed [QW:0] quo_reg;

    logic          take_c [0:QW-1];
    logic [NW-1:0] rem_next [0:QW-2];
    logic [QW-1:0] q_next   [0:QW-1];
    logic          ov_c;
    logic [QW-1:0] mag_c;
    logic [QW:0]   mag_x;
    logic [QW:0]   quo_next;

    assign ov_c = (num >> QW) >= NW'(den);

    always_comb begin
        for (int k = 1; k <= QW; k++) begin
            take_c[k-1] = (rem_reg[k-1] >> (QW - k)) >= NW'(den_reg[k-1]);
            q_next[k-1] = q_reg[k-1] | (QW'(take_c[k-1]) << (QW - k));
        end
        for (int k = 1; k < QW; k++) begin
            rem_next[k-1] = take_c[k-1] ? rem_reg[k-1] - (NW'(den_reg[k-1]) << (QW - k))
                                        : rem_reg[k-1];
        end
    end

    always_comb begin
        mag_c    = ov_reg[QW] ? '1 : q_reg[QW];
        mag_x    = {1'b0, mag_c};
        quo_next = flip_reg[QW] ? (~mag_x + 1'b1) : mag_x;
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            ov_reg[0]   <= ov_c;
            flip_reg[0] <= ctl.flip;
            for (int k = 1; k < QW; k++) begin
                rem_reg[k] <= rem_next[k-1];
                den_reg[k] <= den_reg[k-1];
            end
            for (int k = 1; k <= QW; k++) begin
                q_reg[k] <= q_next[k-1];
            end
            ov_reg[QW:1]   <= ov_reg[QW-1:0];
            flip_reg[QW:1] <= flip_reg[QW-1:0];
            quo_reg        <= $signed(quo_next);
        end
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/ray_triangle_intersect.sv =====
`default_nettype none
// channel   dir  handshake          tuser                       tdata
// s_        in   s_tvalid/s_tready  op, vertex_sel              pos_x/y/z, dir_x/y/z
// m_        out  m_tvalid/m_tready  hit                         distance, hit_x/y/z, beta, gamma
// cfg_      in   cfg_we             -                           cfg_addr selects, cfg_wdata
//
// one item enters every cycle while the output register is free or being taken; a test
// result is offered on m_ once it has passed stages 0 to 6, the one-bit-per-stage
// restoring dividers, stages E1 to E3 and the output register; load items write the
// vertex store at acceptance and give no item
// aresetn clears the vertex store, the configuration registers and all valid bits
// the whole pipeline moves only while the output register is free or being taken,
// so a stall holds every stage in place and s_tready follows it
module ray_triangle_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, zero fill
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]        s_tdata,
    // op, vertex_sel
    input  logic [2:0]                                s_tuser,

    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // distance, hit_x, hit_y, hit_z, bary_beta, bary_gamma, zero fill
    output logic [((6*COORD_WIDTH-1+7)/8)*8-1:0]      m_tdata,
    // hit
    output logic [0:0]                                m_tuser,

    input  logic                                      cfg_we,
    input  logic [1:0]                                cfg_addr,
    input  logic [rti_pkg::CFG_W-1:0]                 cfg_wdata
);

    localparam int W      = COORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int CW_CFG = rti_pkg::CFG_W;
    localparam int OUT_TW = ((6*COORD_WIDTH-1+7)/8)*8;
    localparam int MW     = W + 1;          // matrix entries and right side
    localparam int PW     = 2 * MW;         // pair products
    localparam int CW     = PW + 1;         // 2x2 minors
    localparam int LW     = MW;             // low split of a minor
    localparam int DPW    = CW + MW;        // cofactor times entry
    localparam int DW     = DPW + 2;        // determinants
    localparam int NW     = DW + F;         // scaled numerator magnitude
    localparam int QW     = W + F + 2;      // quotient magnitude bits
    localparam int QSW    = QW + 1;         // signed quotient
    localparam int AW     = QSW + 2;        // barycentric checks
    localparam int LT     = QSW / 2;        // low split of t
    localparam int THW    = QSW - LT;
    localparam int TPW    = QSW + W;        // t times direction
    localparam int SW     = TPW + 1;        // origin plus offset
    localparam int EW     = DW + CW_CFG + 2 * F;
    localparam int DL     = QW + 2;         // length of the miss flag line across the divider
    localparam int E0     = 6 + DL;         // sideband tap at divider output
    localparam int SB_LEN = E0 + 1;

    // minor k = m[MA]*m[MB] - m[MC]*m[MD]; order C00 C10 C20 C01 C11 C21 C02 C12 C22
    localparam int MA [0:8] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int MB [0:8] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int MC [0:8] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int MD [0:8] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    localparam logic signed [TPW-1:0] TRND  = TPW'({F{1'b1}});
    localparam logic signed [TPW-1:0] TZERO = '0;
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    // handshake and stall
    logic adv;
    logic acc;
    logic m_tvalid_reg;
    logic [OUT_TW-1:0] m_tdata_reg;
    logic [0:0] m_tuser_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign acc      = s_tvalid && s_tready;

    // configuration
    logic [CW_CFG-1:0] t_min_reg, tol_reg, eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_min_reg <= rti_pkg::T_MIN_RST;
            tol_reg   <= rti_pkg::TOL_RST;
            eps_reg   <= rti_pkg::EPS_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                rti_pkg::CFG_T_MIN: t_min_reg <= cfg_wdata;
                rti_pkg::CFG_TOL:   tol_reg   <= cfg_wdata;
                rti_pkg::CFG_EPS:   eps_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input unpack
    logic signed [W-1:0] in_pos [0:2];
    logic signed [W-1:0] in_dir [0:2];

    for (genvar k = 0; k < 3; k++) begin : g_unpack
        assign in_pos[k] = s_tdata[k*W +: W];
        assign in_dir[k] = s_tdata[(3+k)*W +: W];
    end

    // vertex store: A xyz, B xyz, C xyz
    logic signed [W-1:0] vs_reg [0:8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) vs_reg[i] <= '0;
        end else if (acc && s_tuser[0] == rti_pkg::OP_LOAD) begin
            unique case (s_tuser[2:1])
                rti_pkg::VSEL_A: for (int k = 0; k < 3; k++) vs_reg[k]     <= in_pos[k];
                rti_pkg::VSEL_B: for (int k = 0; k < 3; k++) vs_reg[3 + k] <= in_pos[k];
                rti_pkg::VSEL_C: for (int k = 0; k < 3; k++) vs_reg[6 + k] <= in_pos[k];
                default: ;   // unused select, load dropped
            endcase
        end
    end

    // sideband line: valid, origin and direction ride along up to the divider output
    logic [SB_LEN-1:0]   sb_vld_reg;
    logic signed [W-1:0] sb_org_reg [0:SB_LEN-1][0:2];
    logic signed [W-1:0] sb_dir_reg [0:SB_LEN-1][0:2];
    logic [DL:0]         dm_reg;     // parallel-ray miss, from stage 6 on

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb_vld_reg <= '0;
        end else if (adv) begin
            sb_vld_reg <= {sb_vld_reg[SB_LEN-2:0], acc && s_tuser[0] == rti_pkg::OP_TEST};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                sb_org_reg[0][k] <= in_pos[k];
                sb_dir_reg[0][k] <= in_dir[k];
            end
            for (int i = 1; i < SB_LEN; i++) begin
                for (int k = 0; k < 3; k++) begin
                    sb_org_reg[i][k] <= sb_org_reg[i-1][k];
                    sb_dir_reg[i][k] <= sb_dir_reg[i-1][k];
                end
            end
        end
    end

    // stage 0: matrix [A-B | A-C | dir] and right side A-origin
    logic signed [MW-1:0] m_reg [0:8];
    logic signed [MW-1:0] r_reg [0:2];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                m_reg[k*3]     <= MW'(vs_reg[k]) - MW'(vs_reg[3 + k]);
                m_reg[k*3 + 1] <= MW'(vs_reg[k]) - MW'(vs_reg[6 + k]);
                m_reg[k*3 + 2] <= MW'(in_dir[k]);
                r_reg[k]       <= MW'(vs_reg[k]) - MW'(in_pos[k]);
            end
        end
    end

    // stage 1: pair products; stage 2: minors (cofactors)
    logic signed [PW-1:0] pp_reg [0:17];
    logic signed [CW-1:0] mn_reg [0:8];
    // first column of the matrix, then the right side
    logic signed [MW-1:0] dv1_reg [0:5];
    logic signed [MW-1:0] dv2_reg [0:5];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 9; c++) begin
                pp_reg[2*c]     <= PW'(m_reg[MA[c]]) * PW'(m_reg[MB[c]]);
                pp_reg[2*c + 1] <= PW'(m_reg[MC[c]]) * PW'(m_reg[MD[c]]);
                mn_reg[c]       <= CW'(pp_reg[2*c]) - CW'(pp_reg[2*c + 1]);
            end
            for (int k = 0; k < 3; k++) begin
                dv1_reg[k]     <= m_reg[k*3];
                dv1_reg[3 + k] <= r_reg[k];
            end
            for (int i = 0; i < 6; i++) dv2_reg[i] <= dv1_reg[i];
        end
    end

    // stage 3: split partial products; stage 4: combine; stage 5: sums
    // group 0 is D, 1 Db, 2 Dg, 3 Dt; Db shares the column-0 cofactors with D, Dg and Dt use column 1 and 2
    logic signed [CW-1:0]  ph_reg [0:11];
    logic signed [CW-1:0]  pl_reg [0:11];
    logic signed [DPW-1:0] dp_reg [0:11];
    logic signed [DW-1:0]  ds_reg [0:3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int g = 0; g < 4; g++) begin
                for (int k = 0; k < 3; k++) begin
                    ph_reg[g*3 + k] <=
                        CW'($signed(mn_reg[(g == 0) ? k : (g - 1)*3 + k][CW-1:LW]))
                        * CW'(dv2_reg[(g == 0) ? k : 3 + k]);
                    pl_reg[g*3 + k] <=
                        CW'($signed({1'b0, mn_reg[(g == 0) ? k : (g - 1)*3 + k][LW-1:0]}))
                        * CW'(dv2_reg[(g == 0) ? k : 3 + k]);
                end
            end
            for (int i = 0; i < 12; i++) begin
                dp_reg[i] <= (DPW'(ph_reg[i]) <<< LW) + DPW'(pl_reg[i]);
            end
            for (int g = 0; g < 4; g++) begin
                ds_reg[g] <= DW'(dp_reg[3*g]) + DW'(dp_reg[3*g + 1]) + DW'(dp_reg[3*g + 2]);
            end
        end
    end

    // stage 6: magnitudes, signs and the parallel test
    logic [DW-1:0] ab_c [0:3];
    logic          dm_c;
    logic [DW-1:0] ud_reg;
    logic [NW-1:0] un_reg [0:2];
    logic [2:0]    sg_reg;

    always_comb begin
        for (int g = 0; g < 4; g++) begin
            ab_c[g] = ds_reg[g][DW-1] ? DW'(-ds_reg[g]) : DW'(ds_reg[g]);
        end
        dm_c = EW'(ab_c[0]) <= (EW'(eps_reg) << (2 * F));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ud_reg <= ab_c[0];
            for (int g = 0; g < 3; g++) begin
                un_reg[g] <= NW'(ab_c[g + 1]) << F;
                sg_reg[g] <= ds_reg[g + 1][DW-1] ^ ds_reg[0][DW-1];
            end
            dm_reg <= {dm_reg[DL-1:0], dm_c};
        end
    end

    // three divider lanes: beta, gamma, t
    logic signed [QW:0] quo [0:2];

    for (genvar g = 0; g < 3; g++) begin : g_div
        rti_pkg::div_ctl_t ctl;
        assign ctl.adv  = adv;
        assign ctl.flip = sg_reg[g];
        rti_div #(
            .NW(NW),
            .DW(DW),
            .QW(QW)
        ) u_div (
            .aclk(aclk),
            .ctl (ctl),
            .num (un_reg[g]),
            .den (ud_reg),
            .quo (quo[g])
        );
    end

    // stage E1: hit decision and split t*dir products
    logic signed [AW-1:0] tol_s, lo_s, hi_s, one_s, b_s, g_s, a_s;
    logic                 hit_c;

    always_comb begin
        tol_s = AW'(tol_reg);
        one_s = AW'(1) <<< F;
        lo_s  = -tol_s;
        hi_s  = one_s + tol_s;
        b_s   = AW'(quo[0]);
        g_s   = AW'(quo[1]);
        a_s   = one_s - b_s - g_s;
        hit_c = !dm_reg[DL]
             && (quo[2] >= $signed({1'b0, t_min_reg}))
             && !(b_s < lo_s) && !(b_s > hi_s)
             && !(g_s < lo_s) && !(g_s > hi_s)
             && !(a_s < lo_s) && !(a_s > hi_s);
    end

    logic                      e1_vld_reg, e1_hit_reg;
    logic signed [QSW-1:0]     e1_t_reg, e1_b_reg, e1_g_reg;
    logic signed [W-1:0]       e1_org_reg [0:2];
    logic signed [THW+W-1:0]   e1_tph_reg [0:2];
    logic signed [LT+W:0]      e1_tpl_reg [0:2];

    logic                      e2_vld_reg, e2_hit_reg;
    logic signed [QSW-1:0]     e2_t_reg, e2_b_reg, e2_g_reg;
    logic signed [W-1:0]       e2_org_reg [0:2];
    logic signed [TPW-1:0]     e2_tp_reg [0:2];

    logic                      e3_vld_reg, e3_hit_reg;
    logic signed [QSW-1:0]     e3_t_reg, e3_b_reg, e3_g_reg;
    logic signed [SW-1:0]      e3_sum_reg [0:2];

    logic signed [TPW-1:0]     tb_c [0:2];
    logic signed [TPW-1:0]     tq_c [0:2];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            // truncate toward zero on the way down by 2^F
            tb_c[k] = e2_tp_reg[k] + (e2_tp_reg[k][TPW-1] ? TRND : TZERO);
            tq_c[k] = tb_c[k] >>> F;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            e3_vld_reg <= 1'b0;
        end else if (adv) begin
            e1_vld_reg <= sb_vld_reg[E0];
            e2_vld_reg <= e1_vld_reg;
            e3_vld_reg <= e2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_hit_reg <= hit_c;
            e1_t_reg   <= quo[2];
            e1_b_reg   <= quo[0];
            e1_g_reg   <= quo[1];
            for (int k = 0; k < 3; k++) begin
                e1_org_reg[k] <= sb_org_reg[E0][k];
                e1_tph_reg[k] <= (THW+W)'($signed(quo[2][QSW-1:LT]))
                               * (THW+W)'(sb_dir_reg[E0][k]);
                e1_tpl_reg[k] <= (LT+W+1)'($signed({1'b0, quo[2][LT-1:0]}))
                               * (LT+W+1)'(sb_dir_reg[E0][k]);
            end

            e2_hit_reg <= e1_hit_reg;
            e2_t_reg   <= e1_t_reg;
            e2_b_reg   <= e1_b_reg;
            e2_g_reg   <= e1_g_reg;
            for (int k = 0; k < 3; k++) begin
                e2_org_reg[k] <= e1_org_reg[k];
                e2_tp_reg[k]  <= (TPW'(e1_tph_reg[k]) <<< LT) + TPW'(e1_tpl_reg[k]);
            end

            e3_hit_reg <= e2_hit_reg;
            e3_t_reg   <= e2_t_reg;
            e3_b_reg   <= e2_b_reg;
            e3_g_reg   <= e2_g_reg;
            for (int k = 0; k < 3; k++) begin
                e3_sum_reg[k] <= SW'(e2_org_reg[k]) + SW'(tq_c[k]);
            end
        end
    end

    // saturation and packing into the output register
    logic [W-2:0] dist_c;
    logic [W-1:0] hp_c [0:2];
    logic [W-1:0] beta_c, gamma_c;

    always_comb begin
        // t is never negative on a hit
        dist_c = (e3_t_reg[QSW-1:W-1] == '0) ? e3_t_reg[W-2:0] : '1;
        for (int k = 0; k < 3; k++) begin
            if (e3_sum_reg[k][SW-1:W-1] == {(SW-W+1){e3_sum_reg[k][SW-1]}}) begin
                hp_c[k] = e3_sum_reg[k][W-1:0];
            end else begin
                hp_c[k] = e3_sum_reg[k][SW-1] ? SMIN : SMAX;
            end
        end
        if (e3_b_reg[QSW-1:W-1] == {(QSW-W+1){e3_b_reg[QSW-1]}}) begin
            beta_c = e3_b_reg[W-1:0];
        end else begin
            beta_c = e3_b_reg[QSW-1] ? SMIN : SMAX;
        end
        if (e3_g_reg[QSW-1:W-1] == {(QSW-W+1){e3_g_reg[QSW-1]}}) begin
            gamma_c = e3_g_reg[W-1:0];
        end else begin
            gamma_c = e3_g_reg[QSW-1] ? SMIN : SMAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= e3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tuser_reg[0] <= e3_hit_reg;
            // a miss reports zeros in every field
            m_tdata_reg <= e3_hit_reg
                ? OUT_TW'({gamma_c, beta_c, hp_c[2], hp_c[1], hp_c[0], dist_c})
                : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // reset empties the output register
    a_rst_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid_reg)
        else $error("output valid after reset");

    // a miss never carries data
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tuser_reg[0] |-> m_tdata_reg == '0)
        else $error("miss item with nonzero data");

    // only accepted tests enter the pipeline
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !(acc && s_tuser[0] == rti_pkg::OP_TEST) |=> !sb_vld_reg[0])
        else $error("pipeline item without an accepted test");

    // a stall freezes the valid line
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(sb_vld_reg) && $stable(e3_vld_reg))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire
